// File: design/first_fit_block_allocator_macros.svh
// Assertion macros used by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Implication checked in the same cycle.
`define FFA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ffa_pkg.sv
// Package with types and constants of the first-fit block allocator.
`default_nettype none

package ffa_pkg;

  // Pool geometry.
  localparam int POOL_UNITS = 4096;
  localparam int UNIT_SHIFT = 6;
  localparam int IDX_W      = $clog2(POOL_UNITS);
  localparam int SIZE_W     = IDX_W + 1;
  localparam int SUM_W      = SIZE_W + 1;

  // Field widths.
  localparam int REQ_W   = 20;
  localparam int ADDR_W  = 20;
  localparam int GRANT_W = 18;
  localparam int THR_W   = 13;
  localparam int NEED_W  = REQ_W - UNIT_SHIFT + 1;
  localparam int UNIT_W  = ADDR_W - UNIT_SHIFT;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FIT   = 2'd1,
    STAT_BAD_ADDR = 2'd2
  } status_t;

  typedef struct packed {
    action_t           action;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [GRANT_W-1:0] grant_address;
    status_t            status;
  } out_item_t;

  // One header word: block size in units and the used mark.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic              used;
  } hdr_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_A_SCAN,
    ST_A_WR1,
    ST_A_WR2,
    ST_F_HDR,
    ST_F_NXT,
    ST_F_PRV,
    ST_F_WR,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

// File: design/first_fit_block_allocator.sv
// First-fit block allocator with boundary-tag coalescing, held in two header memories.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------------------
//   in_     | input     | in_valid/in_ready   | in_item: action, request_bytes, free_address
//   out_    | output    | out_valid/out_ready | out_item: grant_address, status
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_data: split threshold in units
//
// An allocate walks the header memory one read per cycle from the search start, then on
// success writes the chosen and remainder headers in ST_A_WR1 and ST_A_WR2.
// A free does three header reads and two write steps; a bad address goes straight to ST_RESP.
// After reset the block writes the header of the initial whole-pool block in ST_INIT.
// A stalled output holds the result register; no new transaction is accepted meanwhile,
// and the FSM waits in ST_RESP until the register is free.
`default_nettype none
`include "first_fit_block_allocator_macros.svh"

module first_fit_block_allocator
  import ffa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [THR_W-1:0] cfg_data
);

  localparam int CW      = SIZE_W + NEED_W + THR_W;
  localparam int GRANT_X = SIZE_W + UNIT_SHIFT;

  // Header memories.
  hdr_t              hdr_mem  [POOL_UNITS];
  logic [SIZE_W-1:0] prev_mem [POOL_UNITS];

  hdr_t              hdr_rd_r;
  logic [SIZE_W-1:0] prev_rd_r;
  logic              hdr_we;
  logic [IDX_W-1:0]  hdr_waddr, hdr_raddr;
  hdr_t              hdr_wdata;
  logic              prev_we;
  logic [IDX_W-1:0]  prev_waddr, prev_raddr;
  logic [SIZE_W-1:0] prev_wdata;

  // Control and working registers.
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  start_r, start_nxt;
  logic [THR_W-1:0]  thr_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;
  out_item_t         res_r, res_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [SIZE_W-1:0] size_b_r, size_b_nxt;
  logic [SIZE_W-1:0] prv_r, prv_nxt;
  logic [SIZE_W-1:0] rest_r, rest_nxt;
  logic [IDX_W-1:0]  fresh_r, fresh_nxt;
  logic [IDX_W-1:0]  after_r, after_nxt;
  logic              fresh_ok_r, fresh_ok_nxt;
  logic              after_ok_r, after_ok_nxt;
  logic              nxt_ok_r, nxt_ok_nxt;
  logic              prv_ok_r, prv_ok_nxt;
  logic              merge_r, merge_nxt;

  // Datapath terms.
  logic [NEED_W-1:0] need_calc;
  logic [UNIT_W-1:0] unit_idx;
  logic              addr_bad;
  logic [IDX_W-1:0]  free_blk;
  logic [SUM_W-1:0]  scan_next;
  logic              scan_fit;
  logic [SIZE_W-1:0] need_sz;
  logic [SIZE_W-1:0] rest;
  logic              split;
  logic [SUM_W-1:0]  fresh_sum;
  logic [SUM_W-1:0]  fin_next;
  logic [GRANT_X-1:0] grant_wide;

  // Request size in units, with one header unit added.
  assign need_calc = NEED_W'(({1'b0, in_item.request_bytes}
                              + (REQ_W+1)'((1 << UNIT_SHIFT) - 1)) >> UNIT_SHIFT)
                     + NEED_W'(1);

  // Free address decode.
  assign unit_idx = in_item.free_address[ADDR_W-1:UNIT_SHIFT];
  assign addr_bad = (unit_idx == '0) || (32'(unit_idx) >= 32'(POOL_UNITS));
  assign free_blk = IDX_W'(unit_idx - UNIT_W'(1));

  // Header walk and fit test on the word just read.
  assign scan_next = SUM_W'(idx_r) + SUM_W'(hdr_rd_r.size);
  assign scan_fit  = !hdr_rd_r.used && (CW'(hdr_rd_r.size) >= CW'(need_r));
  assign need_sz   = SIZE_W'(need_r);
  assign rest      = hdr_rd_r.size - need_sz;
  assign split     = CW'(rest) > CW'(thr_r);
  assign fresh_sum = SUM_W'(idx_r) + SUM_W'(need_sz);
  assign fin_next  = SUM_W'(idx_r) + SUM_W'(size_b_r);
  assign grant_wide = GRANT_X'(SIZE_W'(idx_r) + SIZE_W'(1)) << UNIT_SHIFT;

  // Synchronous memories with registered read data.
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[hdr_waddr] <= hdr_wdata;
    end
    hdr_rd_r <= hdr_mem[hdr_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    prev_rd_r <= prev_mem[prev_raddr];
  end

  // Next state, memory accesses and working values.
  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    res_nxt       = res_r;
    idx_nxt       = idx_r;
    need_nxt      = need_r;
    size_b_nxt    = size_b_r;
    prv_nxt       = prv_r;
    rest_nxt      = rest_r;
    fresh_nxt     = fresh_r;
    after_nxt     = after_r;
    fresh_ok_nxt  = fresh_ok_r;
    after_ok_nxt  = after_ok_r;
    nxt_ok_nxt    = nxt_ok_r;
    prv_ok_nxt    = prv_ok_r;
    merge_nxt     = merge_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    hdr_we        = 1'b0;
    hdr_waddr     = idx_r;
    hdr_wdata     = '{size: size_b_r, used: 1'b0};
    hdr_raddr     = idx_r;
    prev_we       = 1'b0;
    prev_waddr    = idx_r;
    prev_wdata    = SIZE_W'(idx_r);
    prev_raddr    = free_blk;

    unique case (state_r)
      ST_INIT: begin
        // The whole pool starts as one free block with no predecessor.
        hdr_we     = 1'b1;
        hdr_waddr  = '0;
        hdr_wdata  = '{size: SIZE_W'(POOL_UNITS), used: 1'b0};
        prev_we    = 1'b1;
        prev_waddr = '0;
        prev_wdata = SIZE_W'(POOL_UNITS);
        state_nxt  = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.action == ACT_ALLOC) begin
            idx_nxt   = start_r;
            need_nxt  = need_calc;
            hdr_raddr = start_r;
            state_nxt = ST_A_SCAN;
          end else if (addr_bad) begin
            res_nxt   = '{grant_address: '0, status: STAT_BAD_ADDR};
            state_nxt = ST_RESP;
          end else begin
            idx_nxt   = free_blk;
            hdr_raddr = free_blk;
            state_nxt = ST_F_HDR;
          end
        end
      end
      ST_A_SCAN: begin
        // One header per cycle: test it and fetch the following one.
        if (hdr_rd_r.size == '0) begin
          res_nxt   = '{grant_address: '0, status: STAT_NO_FIT};
          state_nxt = ST_RESP;
        end else if (scan_fit) begin
          size_b_nxt   = split ? need_sz : hdr_rd_r.size;
          rest_nxt     = rest;
          fresh_nxt    = IDX_W'(fresh_sum);
          after_nxt    = IDX_W'(scan_next);
          fresh_ok_nxt = split && (fresh_sum < SUM_W'(POOL_UNITS));
          after_ok_nxt = scan_next < SUM_W'(POOL_UNITS);
          state_nxt    = ST_A_WR1;
        end else if (scan_next >= SUM_W'(POOL_UNITS)) begin
          res_nxt   = '{grant_address: '0, status: STAT_NO_FIT};
          state_nxt = ST_RESP;
        end else begin
          idx_nxt   = IDX_W'(scan_next);
          hdr_raddr = IDX_W'(scan_next);
        end
      end
      ST_A_WR1: begin
        // Mark the chosen block used; link the remainder back to it.
        hdr_we     = 1'b1;
        hdr_wdata  = '{size: size_b_r, used: 1'b1};
        prev_we    = fresh_ok_r;
        prev_waddr = fresh_r;
        prev_wdata = SIZE_W'(idx_r);
        state_nxt  = ST_A_WR2;
      end
      ST_A_WR2: begin
        // Write the remainder header and relink the block after it.
        hdr_we     = fresh_ok_r;
        hdr_waddr  = fresh_r;
        hdr_wdata  = '{size: rest_r, used: 1'b0};
        prev_we    = fresh_ok_r && after_ok_r;
        prev_waddr = after_r;
        prev_wdata = SIZE_W'(fresh_r);
        if (fresh_ok_r && (start_r == idx_r)) begin
          start_nxt = fresh_r;
        end
        res_nxt   = '{grant_address: GRANT_W'(grant_wide), status: STAT_OK};
        state_nxt = ST_RESP;
      end
      ST_F_HDR: begin
        // A block not in use is left alone.
        if (!hdr_rd_r.used) begin
          res_nxt   = '{grant_address: '0, status: STAT_OK};
          state_nxt = ST_RESP;
        end else begin
          size_b_nxt = hdr_rd_r.size;
          prv_nxt    = prev_rd_r;
          nxt_ok_nxt = scan_next < SUM_W'(POOL_UNITS);
          hdr_raddr  = IDX_W'(scan_next);
          state_nxt  = ST_F_NXT;
        end
      end
      ST_F_NXT: begin
        // Absorb a free successor, then fetch the predecessor.
        if (nxt_ok_r && !hdr_rd_r.used) begin
          size_b_nxt = size_b_r + hdr_rd_r.size;
        end
        prv_ok_nxt = prv_r < SIZE_W'(POOL_UNITS);
        hdr_raddr  = IDX_W'(prv_r);
        state_nxt  = ST_F_PRV;
      end
      ST_F_PRV: begin
        // Release the block; merge into a free predecessor.
        hdr_we    = 1'b1;
        merge_nxt = prv_ok_r && !hdr_rd_r.used;
        if (prv_ok_r && !hdr_rd_r.used) begin
          idx_nxt    = IDX_W'(prv_r);
          size_b_nxt = hdr_rd_r.size + size_b_r;
        end
        state_nxt = ST_F_WR;
      end
      ST_F_WR: begin
        // Grow the predecessor and relink the block after the result.
        hdr_we     = merge_r;
        prev_we    = fin_next < SUM_W'(POOL_UNITS);
        prev_waddr = IDX_W'(fin_next);
        if (start_r >= idx_r) begin
          start_nxt = idx_r;
        end
        res_nxt   = '{grant_address: '0, status: STAT_OK};
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_item_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      start_r     <= '0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
    idx_r      <= idx_nxt;
    need_r     <= need_nxt;
    size_b_r   <= size_b_nxt;
    prv_r      <= prv_nxt;
    rest_r     <= rest_nxt;
    fresh_r    <= fresh_nxt;
    after_r    <= after_nxt;
    fresh_ok_r <= fresh_ok_nxt;
    after_ok_r <= after_ok_nxt;
    nxt_ok_r   <= nxt_ok_nxt;
    prv_ok_r   <= prv_ok_nxt;
    merge_r    <= merge_nxt;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks on sequencing and results.
  `FFA_ASSERT_SAME(a_no_write_idle, in_ready, !hdr_we && !prev_we, "header write while idle")
  `FFA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second transaction taken early")
  `FFA_ASSERT_SAME(a_fail_no_grant, out_valid && (out_item.status != STAT_OK), out_item.grant_address == '0, "grant on failed transaction")
  `FFA_ASSERT_NEXT(a_resp_loads, (state_r == ST_RESP) && (!out_valid_r || out_ready), out_valid_r && (state_r == ST_IDLE), "result not delivered")

endmodule

`default_nettype wire
